[src/i2cms_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
// Holds the command and pin-action codes and the item and result structs.
// No dependencies.
package i2cms_pkg;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_RECV  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_RACK  = 3'd6;
  localparam logic [2:0] OP_SPARE = 3'd7;

  typedef logic [2:0] act_t;

  localparam act_t ACT_SCL0 = 3'd0;
  localparam act_t ACT_SCL1 = 3'd1;
  localparam act_t ACT_SDA0 = 3'd2;
  localparam act_t ACT_SDA1 = 3'd3;
  localparam act_t ACT_DATA = 3'd4;
  localparam act_t ACT_ACK  = 3'd5;
  localparam act_t ACT_READ = 3'd6;

  localparam logic [15:0] STEP_TICKS_RESET = 16'd720;

  typedef struct packed {
    logic       sda_line;
    logic       ack_bit;
    logic [7:0] data_byte;
    logic [2:0] kind;
  } item_t;

  typedef struct packed {
    logic       rejected;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl_drive;
  } result_t;

  // Number of pin steps in each command.
  function automatic logic [4:0] step_count(input logic [2:0] op);
    logic [4:0] n;
    case (op)
      OP_START: n = 5'd4;
      OP_STOP:  n = 5'd3;
      OP_SEND:  n = 5'd24;
      OP_RECV:  n = 5'd25;
      OP_SACK:  n = 5'd3;
      OP_RACK:  n = 5'd4;
      default:  n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

[src/i2cms_step_decode.sv]
// Pin-action decoder: maps a command and a step index to the action of that step.
// Depends on i2cms_pkg.
module i2cms_step_decode
  import i2cms_pkg::*;
(
  input  logic [2:0] op,
  input  logic [4:0] idx,
  output act_t       act
);

  logic [1:0] phase;

  // Index modulo three, from a small table.
  always_comb begin
    case (idx)
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30: phase = 2'd0;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31: phase = 2'd1;
      default: phase = 2'd2;
    endcase
  end

  always_comb begin
    case (op)
      OP_START: begin
        case (idx[1:0])
          2'd0:    act = ACT_SDA1;
          2'd1:    act = ACT_SCL1;
          2'd2:    act = ACT_SDA0;
          default: act = ACT_SCL0;
        endcase
      end
      OP_STOP: begin
        case (phase)
          2'd0:    act = ACT_SDA0;
          2'd1:    act = ACT_SCL1;
          default: act = ACT_SDA1;
        endcase
      end
      OP_SEND, OP_SACK: begin
        case (phase)
          2'd0:    act = (op == OP_SEND) ? ACT_DATA : ACT_ACK;
          2'd1:    act = ACT_SCL1;
          default: act = ACT_SCL0;
        endcase
      end
      OP_RECV: begin
        if (idx == 5'd0) begin
          act = ACT_SDA1;
        end else begin
          case (phase)
            2'd1:    act = ACT_SCL1;
            2'd2:    act = ACT_READ;
            default: act = ACT_SCL0;
          endcase
        end
      end
      OP_RACK: begin
        case (idx[1:0])
          2'd0:    act = ACT_SDA1;
          2'd1:    act = ACT_SCL1;
          2'd2:    act = ACT_READ;
          default: act = ACT_SCL0;
        endcase
      end
      default: act = ACT_READ;
    endcase
  end

endmodule

[src/i2cms_engine.sv]
// Sequencer state and per-request update: commands, step timing and pin writes.
// Depends on i2cms_pkg and i2cms_step_decode.
module i2cms_engine
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  item_t       item,
  input  logic [15:0] step_ticks,
  output result_t     res
);

  logic [2:0]  op, op_next;
  logic [4:0]  idx, idx_next;
  logic [15:0] timer, timer_next;
  logic [7:0]  shift, shift_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        ack, ack_next;
  logic [7:0]  last_read, last_read_next;

  act_t cmd_act, cur_act, nxt_act;
  logic [4:0] idx_inc;

  assign idx_inc = idx + 5'd1;

  i2cms_step_decode u_cmd_dec (.op(item.kind), .idx(5'd0),    .act(cmd_act));
  i2cms_step_decode u_cur_dec (.op(op),        .idx(idx),     .act(cur_act));
  i2cms_step_decode u_nxt_dec (.op(op),        .idx(idx_inc), .act(nxt_act));

  always_comb begin
    logic        is_cmd;
    logic [15:0] limit;
    logic [15:0] timer_inc;
    logic        wr_en;
    act_t        wr_act;
    logic        wr_ack;
    logic        done;
    logic        rej;

    op_next        = op;
    idx_next       = idx;
    timer_next     = timer;
    shift_next     = shift;
    scl_next       = scl;
    sda_next       = sda;
    ack_next       = ack;
    last_read_next = last_read;
    done           = 1'b0;
    rej            = 1'b0;
    wr_en          = 1'b0;
    wr_act         = ACT_READ;
    wr_ack         = 1'b0;

    is_cmd    = (item.kind != OP_IDLE) && (item.kind != OP_SPARE);
    limit     = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
    timer_inc = timer + 16'd1;

    if (is_cmd) begin
      if (op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        op_next    = item.kind;
        idx_next   = 5'd0;
        timer_next = 16'd0;
        if (item.kind == OP_SEND) begin
          shift_next = item.data_byte;
        end else if (item.kind == OP_RECV) begin
          shift_next = 8'd0;
        end
        wr_en  = 1'b1;
        wr_act = cmd_act;
        wr_ack = item.ack_bit;
      end
    end else if (op != OP_IDLE) begin
      timer_next = timer_inc;
      if (timer_inc >= limit) begin
        if (cur_act == ACT_READ) begin
          if (op == OP_RECV) begin
            shift_next = {shift[6:0], item.sda_line};
          end else begin
            ack_next = item.sda_line;
          end
        end
        timer_next = 16'd0;
        if (idx_inc >= step_count(op)) begin
          if (op == OP_RECV) begin
            last_read_next = shift_next;
          end
          op_next  = OP_IDLE;
          idx_next = 5'd0;
          done     = 1'b1;
        end else begin
          idx_next = idx_inc;
          wr_en    = 1'b1;
          wr_act   = nxt_act;
        end
      end
    end

    if (wr_en) begin
      case (wr_act)
        ACT_SCL0: scl_next = 1'b0;
        ACT_SCL1: scl_next = 1'b1;
        ACT_SDA0: sda_next = 1'b0;
        ACT_SDA1: sda_next = 1'b1;
        ACT_DATA: begin
          sda_next   = shift_next[7];
          shift_next = {shift_next[6:0], 1'b0};
        end
        ACT_ACK:  sda_next = wr_ack;
        default: ;
      endcase
    end

    res.scl_drive = scl_next;
    res.sda_drive = sda_next;
    res.busy_res  = (op_next != OP_IDLE);
    res.done_res  = done;
    res.read_byte = last_read_next;
    res.ack_seen  = ack_next;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= OP_IDLE;
      idx       <= 5'd0;
      timer     <= 16'd0;
      shift     <= 8'd0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      ack       <= 1'b0;
      last_read <= 8'd0;
    end else if (en) begin
      op        <= op_next;
      idx       <= idx_next;
      timer     <= timer_next;
      shift     <= shift_next;
      scl       <= scl_next;
      sda       <= sda_next;
      ack       <= ack_next;
      last_read <= last_read_next;
    end
  end

endmodule

[src/i2c_master_bit_sequencer.sv]
// I2C master bit sequencer: one request per clock, with no gap needed between requests.
// Each request (a tick or a command) is held in an input register, applied to the
// sequencer state from there, and its result is held in an output register. The only
// stall is m_tready low; while a result waits, one more request can still be taken
// into the input register.
// Depends on i2cms_pkg and i2cms_engine.
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], ack_bit[8], sda_line[9], zero fill
  input  logic [2:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_drive, sda_drive, busy_res, done_res,
                                 // read_byte[11:4], ack_seen, rejected, zero fill
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        in_valid;
  item_t       in_item;
  logic        advance;
  logic        out_valid;
  result_t     out_res;
  result_t     res;
  logic [15:0] step_ticks;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks <= STEP_TICKS_RESET;
    end else if (cfg_we) begin
      step_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind      <= s_tuser;
      in_item.data_byte <= s_tdata[7:0];
      in_item.ack_bit   <= s_tdata[8];
      in_item.sda_line  <= s_tdata[9];
    end
  end

  i2cms_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .en        (in_valid && advance),
    .item      (in_item),
    .step_ticks(step_ticks),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done shown while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13] |-> m_tdata[2])
    else $error("request rejected while idle");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("held request lost during stall");

endmodule

[sim/tb.sv]
// Testbench for the I2C master bit sequencer: drives tick and command requests into
// the input stream, predicts the pin and status result of each request and checks it.
// Depends on i2cms_pkg and i2c_master_bit_sequencer.
module tb;
  import i2cms_pkg::*;

  localparam int CYCLE_LIMIT = 8_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = OP_IDLE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  i2c_master_bit_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the sequencer state.
  logic [15:0] ticks_per_step = STEP_TICKS_RESET;
  logic [2:0]  seq_op = OP_IDLE;
  logic [4:0]  seq_step = '0;
  logic [15:0] seq_timer = '0;
  logic [7:0]  seq_shift = '0;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;
  logic        ack_lvl = 1'b0;
  logic [7:0]  byte_read = '0;

  result_t bus_states_due[$];
  int      live_requests = 0;
  int      fail_count = 0;
  int      cycle_count = 0;
  int      rx_hold = 0;
  bit      tx_gaps = 1'b1;
  bit      rx_gaps = 1'b1;

  initial forever #1 clk = ~clk;

  function automatic logic [4:0] steps_in(input logic [2:0] op);
    case (op)
      OP_START: return 5'd4;
      OP_STOP:  return 5'd3;
      OP_SEND:  return 5'd24;
      OP_RECV:  return 5'd25;
      OP_SACK:  return 5'd3;
      OP_RACK:  return 5'd4;
      default:  return 5'd0;
    endcase
  endfunction

  function automatic act_t pin_action(input logic [2:0] op, input logic [4:0] idx);
    int m3;
    int r3;
    m3 = idx % 3;
    r3 = (idx == 0) ? 0 : (idx - 1) % 3;
    case (op)
      OP_START: begin
        case (idx[1:0])
          2'd0: return ACT_SDA1;
          2'd1: return ACT_SCL1;
          2'd2: return ACT_SDA0;
          default: return ACT_SCL0;
        endcase
      end
      OP_STOP: return (m3 == 0) ? ACT_SDA0 : (m3 == 1) ? ACT_SCL1 : ACT_SDA1;
      OP_SEND: return (m3 == 0) ? ACT_DATA : (m3 == 1) ? ACT_SCL1 : ACT_SCL0;
      OP_RECV: begin
        if (idx == 0) return ACT_SDA1;
        return (r3 == 0) ? ACT_SCL1 : (r3 == 1) ? ACT_READ : ACT_SCL0;
      end
      OP_SACK: return (m3 == 0) ? ACT_ACK : (m3 == 1) ? ACT_SCL1 : ACT_SCL0;
      OP_RACK: begin
        case (idx[1:0])
          2'd0: return ACT_SDA1;
          2'd1: return ACT_SCL1;
          2'd2: return ACT_READ;
          default: return ACT_SCL0;
        endcase
      end
      default: return ACT_READ;
    endcase
  endfunction

  function automatic void drive_pins(input act_t a, input logic ack);
    case (a)
      ACT_SCL0: scl_lvl = 1'b0;
      ACT_SCL1: scl_lvl = 1'b1;
      ACT_SDA0: sda_lvl = 1'b0;
      ACT_SDA1: sda_lvl = 1'b1;
      ACT_DATA: begin
        sda_lvl = seq_shift[7];
        seq_shift = {seq_shift[6:0], 1'b0};
      end
      ACT_ACK: sda_lvl = ack;
      default: ;
    endcase
  endfunction

  task automatic predict_bus_state(input logic [2:0] kind, input logic [7:0] data,
                                   input logic ack, input logic line);
    result_t r;
    logic [15:0] lim;
    r = '0;
    if (kind != OP_IDLE && kind != OP_SPARE) begin
      if (seq_op != OP_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        seq_op = kind;
        seq_step = '0;
        seq_timer = '0;
        if (kind == OP_SEND) seq_shift = data;
        else if (kind == OP_RECV) seq_shift = '0;
        drive_pins(pin_action(kind, 5'd0), ack);
        live_requests++;
      end
    end else if (seq_op != OP_IDLE) begin
      live_requests++;
      lim = (ticks_per_step == 16'd0) ? 16'd1 : ticks_per_step;
      seq_timer = seq_timer + 16'd1;
      if (seq_timer >= lim) begin
        if (pin_action(seq_op, seq_step) == ACT_READ) begin
          if (seq_op == OP_RECV) seq_shift = {seq_shift[6:0], line};
          else ack_lvl = line;
        end
        seq_timer = '0;
        seq_step = seq_step + 5'd1;
        if (seq_step >= steps_in(seq_op)) begin
          if (seq_op == OP_RECV) byte_read = seq_shift;
          seq_op = OP_IDLE;
          seq_step = '0;
          r.done_res = 1'b1;
        end else begin
          drive_pins(pin_action(seq_op, seq_step), 1'b0);
        end
      end
    end
    r.scl_drive = scl_lvl;
    r.sda_drive = sda_lvl;
    r.busy_res  = (seq_op != OP_IDLE);
    r.read_byte = byte_read;
    r.ack_seen  = ack_lvl;
    bus_states_due.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h, actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[13:0]);
      if (bus_states_due.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
      end else begin
        want = bus_states_due.pop_front();
        check_field("scl_drive", want.scl_drive, got.scl_drive);
        check_field("sda_drive", want.sda_drive, got.sda_drive);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("ack_seen", want.ack_seen, got.ack_seen);
        check_field("rejected", want.rejected, got.rejected);
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
      rx_hold = $urandom_range(1, 4) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_req(input logic [2:0] kind, input logic [7:0] data,
                          input logic ack, input logic line);
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'b0, line, ack, data};
    do @(posedge clk); while (!s_tready);
    predict_bus_state(kind, data, ack, line);
  endtask

  // Line mode 0 or 1 holds SDA at that level, 2 makes it random.
  task automatic run_to_idle(input int line_mode, input int stray_per_mille);
    logic line;
    while (seq_op != OP_IDLE) begin
      line = (line_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(line_mode);
      if (stray_per_mille > 0 && $urandom_range(0, 999) < stray_per_mille)
        send_req(3'($urandom_range(1, 6)), 8'($urandom), 1'($urandom), line);
      else
        send_req(($urandom_range(0, 15) == 0) ? OP_SPARE : OP_IDLE, 8'($urandom),
                 1'($urandom), line);
    end
  endtask

  task automatic run_cmd(input logic [2:0] kind, input logic [7:0] data,
                         input logic ack, input int line_mode);
    send_req(kind, data, ack, 1'($urandom_range(0, 1)));
    run_to_idle(line_mode, 0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (bus_states_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // The sequencer may be part way through a command; only the stream must be empty.
  task automatic load_step_ticks(input logic [15:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ticks_per_step = value;
  endtask

  task automatic set_step_ticks(input logic [15:0] value);
    run_to_idle(2, 0);
    load_step_ticks(value);
  endtask

  task automatic random_burst(input int target);
    int first;
    first = live_requests;
    while (live_requests - first < target) begin
      case ($urandom_range(0, 9))
        0: send_req(($urandom_range(0, 1) == 0) ? OP_IDLE : OP_SPARE, 8'($urandom),
                    1'($urandom), 1'($urandom));
        1: if (tx_gaps && $urandom_range(0, 3) == 0) wait_drained();
        default: begin
          send_req(3'($urandom_range(1, 6)), 8'($urandom), 1'($urandom), 1'($urandom));
          run_to_idle(2, 30);
        end
      endcase
    end
  endtask

  // Idle ticks, then a start and a refused stop; the start's first step runs the full reset
  // step length, and the rest of it and a receive ack run at a short step.
  task automatic test_reset_rate();
    send_req(OP_IDLE, 8'h00, 1'b0, 1'b0);
    send_req(OP_SPARE, 8'hFF, 1'b1, 1'b1);
    send_req(OP_START, 8'h00, 1'b0, 1'b1);
    send_req(OP_STOP, 8'hFF, 1'b1, 1'b0);
    repeat (int'(STEP_TICKS_RESET) + 1)
      send_req(OP_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
    load_step_ticks(16'd1);
    run_to_idle(2, 0);
    run_cmd(OP_RACK, 8'h00, 1'b0, 1);
  endtask

  task automatic test_each_command();
    set_step_ticks(16'd1);
    run_cmd(OP_SEND, 8'h00, 1'b0, 2);
    run_cmd(OP_SEND, 8'hFF, 1'b1, 2);
    run_cmd(OP_SEND, 8'hA5, 1'b0, 2);
    run_cmd(OP_RECV, 8'h00, 1'b0, 1);
    run_cmd(OP_RECV, 8'hFF, 1'b0, 0);
    run_cmd(OP_RECV, 8'h3C, 1'b1, 2);
    run_cmd(OP_SACK, 8'h00, 1'b0, 2);
    run_cmd(OP_SACK, 8'h00, 1'b1, 2);
    run_cmd(OP_RACK, 8'h00, 1'b0, 0);
    run_cmd(OP_RACK, 8'h00, 1'b0, 1);
    run_cmd(OP_START, 8'h00, 1'b0, 2);
    run_cmd(OP_STOP, 8'h00, 1'b0, 2);
    // Every command kind is refused while a receive is under way.
    send_req(OP_RECV, 8'h00, 1'b0, 1'b0);
    for (int k = OP_START; k <= OP_RACK; k++)
      send_req(3'(k), 8'($urandom), 1'($urandom), 1'($urandom));
    send_req(OP_SPARE, 8'h00, 1'b0, 1'b1);
    run_to_idle(2, 0);
  endtask

  task automatic test_zero_ticks();
    set_step_ticks(16'd0);
    run_cmd(OP_RACK, 8'h00, 1'b0, 1);
    run_cmd(OP_SEND, 8'($urandom), 1'b0, 2);
    run_cmd(OP_RECV, 8'h00, 1'b0, 2);
  endtask

  // A stop at the longest step, cut short by a smaller step length part way through.
  task automatic test_long_steps();
    set_step_ticks(16'hFFFF);
    send_req(OP_STOP, 8'h00, 1'b0, 1'b0);
    send_req(OP_START, 8'h00, 1'b0, 1'b0);
    repeat (20) send_req(OP_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
    load_step_ticks(16'd2);
    run_to_idle(2, 0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      set_step_ticks(16'($urandom_range(0, 4)));
      random_burst(20);
    end
  endtask

  task automatic test_quiet_tail();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_step_ticks(16'($urandom_range(1, 3)));
    random_burst(30);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_rate();
    test_each_command();
    test_zero_ticks();
    test_long_steps();
    test_random_traffic();
    test_quiet_tail();
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/i2cms_pkg.sv
src/i2cms_step_decode.sv
src/i2cms_engine.sv
src/i2c_master_bit_sequencer.sv
sim/tb.sv
